/* design/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* design/ctrgb_pkg.sv */
`timescale 1ns / 1ps
package ctrgb_pkg;

    typedef logic [32:0] tab_t [256];

    typedef struct packed {
        logic lo;
        logic b_one;
        logic b_zero;
    } band_t;

    localparam logic [14:0] T_MIN    = 15'd1000;
    localparam logic [14:0] T_MAX    = 15'd20000;
    localparam logic [14:0] T_KNEE   = 15'd6600;
    localparam logic [14:0] T_BLUE0  = 15'd1900;
    localparam logic [14:0] T_RG_OFF = 15'd6000;
    localparam logic [14:0] T_B_OFF  = 15'd1000;

    function automatic logic [35:0] to_q(input real x);
        return 36'(longint'(x * 4294967296.0));
    endfunction

    function automatic tab_t gen_ln_tab();
        tab_t tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = 33'(longint'($ln(1.0 + real'(i) / 256.0) * 4294967296.0));
        end
        return tab;
    endfunction

    function automatic tab_t gen_rcp_tab();
        tab_t tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = 33'(longint'(4294967296.0 * $pow(1.0 + real'(i) / 256.0, -1.0)));
        end
        return tab;
    endfunction

    function automatic tab_t gen_exp_tab();
        tab_t tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = 33'(longint'($exp(-real'(i) / 256.0) * 4294967296.0));
        end
        return tab;
    endfunction

    localparam tab_t LN_TAB  = gen_ln_tab();
    localparam tab_t RCP_TAB = gen_rcp_tab();
    localparam tab_t EXP_TAB = gen_exp_tab();

    localparam logic [32:0] ONE_Q   = 33'h1_0000_0000;
    localparam logic [32:0] LN2_Q   = 33'(to_q(0.693147180559945309));
    localparam logic [35:0] LN100_Q = to_q(4.605170185988091368);

    localparam logic [29:0] PR_Q = 30'(to_q(0.1332047592));
    localparam logic [29:0] PG_Q = 30'(to_q(0.0755148492));
    localparam logic [32:0] CR_Q = 33'(to_q(1.29420527207247316));
    localparam logic [32:0] CG_Q = 33'(to_q(1.12989086089529416));
    localparam logic [31:0] AG_Q = 32'(to_q(0.99470802586396710));
    localparam logic [35:0] BG_Q = to_q(1.61118095476228786);
    localparam logic [32:0] AB_Q = 33'(to_q(1.38517731223101504));
    localparam logic [35:0] BB_Q = to_q(3.05044858510917239);

endpackage

/* design/ctrgb_log.sv */
`timescale 1ns / 1ps
module ctrgb_log (
    input  logic        aclk,
    input  logic        en,
    input  logic [14:0] n,
    output logic [34:0] ln_q
);
    import ctrgb_pkg::*;

    logic [3:0]  k;
    logic [14:0] m;
    logic [3:0]  k_reg;
    logic [7:0]  idx_reg;
    logic [5:0]  d_reg;
    logic [24:0] u_next, u_reg, u3s_reg;
    logic [35:0] base_next, base_reg, base3_reg, base4_reg;
    logic [16:0] u2_next, u2_reg;
    logic [8:0]  u3_next, u3_reg;
    logic [35:0] s_next, s_reg;
    logic [8:0]  third;
    logic [34:0] ln_reg;

    always_comb begin
        k = 4'd0;
        for (int i = 0; i < 15; i++) begin
            if (n[i]) k = 4'(i);
        end
        m = n << (4'd14 - k);
    end

    assign u_next    = 25'((39'(d_reg) * 39'(RCP_TAB[idx_reg])) >> 14);
    assign base_next = 36'(k_reg) * 36'(LN2_Q) + 36'(LN_TAB[idx_reg]) - LN100_Q;
    assign u2_next   = 17'((50'(u_reg) * 50'(u_reg)) >> 32);
    assign u3_next   = 9'((42'(u2_reg) * 42'(u3s_reg)) >> 32);
    assign s_next    = 36'(u3s_reg) - 36'(u2_reg >> 1);
    assign third     = 9'((18'(u3_reg) * 18'd171) >> 9);

    always_ff @(posedge aclk) begin
        if (en) begin
            k_reg     <= k;
            idx_reg   <= m[13:6];
            d_reg     <= m[5:0];
            u_reg     <= u_next;
            base_reg  <= base_next;
            u3s_reg   <= u_reg;
            u2_reg    <= u2_next;
            base3_reg <= base_reg;
            u3_reg    <= u3_next;
            s_reg     <= s_next;
            base4_reg <= base3_reg;
            ln_reg    <= 35'(base4_reg + s_reg + 36'(third));
        end
    end

    assign ln_q = ln_reg;
endmodule

/* design/ctrgb_exp.sv */
`timescale 1ns / 1ps
module ctrgb_exp (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] y,
    output logic [32:0] e
);
    import ctrgb_pkg::*;

    logic [32:0] tab_reg, tab2_reg, tab3_reg;
    logic [23:0] yl_reg;
    logic [15:0] yl2_reg;
    logic [7:0]  yl3_reg;
    logic [32:0] p_reg, q_reg, e_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            tab_reg  <= EXP_TAB[y[31:24]];
            yl_reg   <= y[23:0];
            yl2_reg  <= 16'((48'(y[23:0]) * 48'(y[23:0])) >> 32);
            tab2_reg <= tab_reg;
            yl3_reg  <= 8'((40'(yl2_reg) * 40'(yl_reg)) >> 32);
            p_reg    <= ONE_Q - 33'(yl_reg) + 33'(yl2_reg >> 1);
            tab3_reg <= tab2_reg;
            q_reg    <= p_reg - 33'((18'(yl3_reg) * 18'd171) >> 10);
            e_reg    <= 33'((66'(tab3_reg) * 66'(q_reg)) >> 32);
        end
    end

    assign e = e_reg;
endmodule

/* design/color_temperature_to_rgb_gains_core.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Color temperature to RGB gains. Accepts one temperature per clock and returns
// red, green and blue gains; a stall on the result side holds the whole 13-stage
// pipeline, so throughput is one transaction per cycle while m_ready is high.
// The path runs through the log stage, the exponential stage and the multiply
// and rounding stages around them.
module color_temperature_to_rgb_gains_core #(
    parameter int FRAC_BITS = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [14:0] s_temperature_kelvin,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_red_gain,
    output logic [15:0] m_green_gain,
    output logic [15:0] m_blue_gain
);
    import ctrgb_pkg::*;

    localparam int          SH    = 32 - FRAC_BITS;
    localparam logic [35:0] RND   = 36'(1) << (SH - 1);
    localparam logic [35:0] ONE_V = 36'(ONE_Q);
    localparam logic [15:0] ONE_G = 16'(36'(1) << FRAC_BITS);

    function automatic logic [15:0] to_gain(input logic [35:0] v);
        logic [35:0] r;
        r = (v + RND) >> SH;
        if (v >= ONE_V) return ONE_G;
        return 16'(r);
    endfunction

    logic        en;
    logic [12:0] vld_reg;
    band_t       flg_reg [12];
    band_t       band_next;
    logic [14:0] t_sat;
    logic [14:0] n1_reg, n2_reg;
    logic [34:0] l1, l2;
    logic [31:0] yr_reg, yg_reg;
    logic [35:0] gl_reg, bl_reg;
    logic [35:0] vgl_reg [7:10];
    logic [35:0] vb_reg  [7:10];
    logic [32:0] er, eg;
    logic [35:0] vr_reg, vg_reg, vgl11_reg, vb11_reg;
    logic [15:0] red_next, green_next, blue_next;
    logic [15:0] red_reg, green_reg, blue_reg;

    assign en      = !vld_reg[12] || m_ready;
    assign s_ready = en;

    always_comb begin
        if (s_temperature_kelvin < T_MIN) begin
            t_sat = T_MIN;
        end else if (s_temperature_kelvin > T_MAX) begin
            t_sat = T_MAX;
        end else begin
            t_sat = s_temperature_kelvin;
        end
        band_next.lo     = t_sat <= T_KNEE;
        band_next.b_one  = t_sat >= T_KNEE;
        band_next.b_zero = t_sat <= T_BLUE0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[11:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n1_reg     <= band_next.lo ? t_sat : t_sat - T_RG_OFF;
            n2_reg     <= t_sat - T_B_OFF;
            flg_reg[0] <= band_next;
            for (int i = 1; i < 12; i++) begin
                flg_reg[i] <= flg_reg[i-1];
            end
        end
    end

    ctrgb_log u_log_rg (.aclk(aclk), .en(en), .n(n1_reg), .ln_q(l1));
    ctrgb_log u_log_b  (.aclk(aclk), .en(en), .n(n2_reg), .ln_q(l2));

    always_ff @(posedge aclk) begin
        if (en) begin
            yr_reg     <= 32'((65'(PR_Q) * 65'(l1)) >> 32);
            yg_reg     <= 32'((65'(PG_Q) * 65'(l1)) >> 32);
            gl_reg     <= 36'((67'(AG_Q) * 67'(l1)) >> 32);
            bl_reg     <= 36'((68'(AB_Q) * 68'(l2)) >> 32);
            vgl_reg[7] <= (gl_reg > BG_Q) ? gl_reg - BG_Q : '0;
            vb_reg[7]  <= (bl_reg > BB_Q) ? bl_reg - BB_Q : '0;
            for (int i = 8; i <= 10; i++) begin
                vgl_reg[i] <= vgl_reg[i-1];
                vb_reg[i]  <= vb_reg[i-1];
            end
        end
    end

    ctrgb_exp u_exp_r (.aclk(aclk), .en(en), .y(yr_reg), .e(er));
    ctrgb_exp u_exp_g (.aclk(aclk), .en(en), .y(yg_reg), .e(eg));

    always_ff @(posedge aclk) begin
        if (en) begin
            vr_reg    <= 36'((66'(CR_Q) * 66'(er)) >> 32);
            vg_reg    <= 36'((66'(CG_Q) * 66'(eg)) >> 32);
            vgl11_reg <= vgl_reg[10];
            vb11_reg  <= vb_reg[10];
        end
    end

    always_comb begin
        red_next   = flg_reg[11].lo ? to_gain(ONE_V) : to_gain(vr_reg);
        green_next = flg_reg[11].lo ? to_gain(vgl11_reg) : to_gain(vg_reg);
        if (flg_reg[11].b_one) begin
            blue_next = to_gain(ONE_V);
        end else if (flg_reg[11].b_zero) begin
            blue_next = '0;
        end else begin
            blue_next = to_gain(vb11_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_valid      = vld_reg[12];
    assign m_red_gain   = red_reg;
    assign m_green_gain = green_reg;
    assign m_blue_gain  = blue_reg;

    `ASSERT_PROP(a_stall_holds, aclk, aresetn, !en |=> $stable(vld_reg))
    `ASSERT_PROP(a_enter, aclk, aresetn, (s_valid && s_ready) |=> vld_reg[0])
    `ASSERT_NEVER(a_gain_range, aclk, aresetn, m_valid && FRAC_BITS <= 15 && (m_red_gain > ONE_G || m_green_gain > ONE_G || m_blue_gain > ONE_G))
endmodule

/* verif/color_temperature_to_rgb_gains_checker.sv */
`timescale 1ns / 1ps
module color_temperature_to_rgb_gains_checker #(
    parameter int FRAC_BITS = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [14:0] s_temperature_kelvin,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_red_gain,
    input  logic [15:0] m_green_gain,
    input  logic [15:0] m_blue_gain,
    output int          pending,
    output int          errors
);
    import ctrgb_pkg::*;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } gains_t;

    gains_t gains_q[$];

    function automatic logic [15:0] quantize_gain(input real v);
        real scaled;
        if (v <= 0.0) begin
            return 16'd0;
        end
        if (v >= 1.0) begin
            return 16'((64'd1 << FRAC_BITS) & 64'hFFFF);
        end
        scaled = v * (2.0 ** FRAC_BITS) + 0.5;
        return 16'(longint'($floor(scaled)) & 64'hFFFF);
    endfunction

    function automatic gains_t blackbody_gains(input logic [14:0] kelvin);
        int k;
        real t, r, g, b;
        gains_t res;
        k = int'(kelvin);
        if (k < int'(T_MIN)) k = int'(T_MIN);
        if (k > int'(T_MAX)) k = int'(T_MAX);
        t = real'(k) / 100.0;
        if (k <= int'(T_KNEE)) begin
            r = 1.0;
            g = 0.99470802586396710 * $ln(t) - 1.61118095476228786;
        end else begin
            r = 1.29420527207247316 * $pow(t - 60.0, -0.1332047592);
            g = 1.12989086089529416 * $pow(t - 60.0, -0.0755148492);
        end
        if (k >= int'(T_KNEE)) begin
            b = 1.0;
        end else if (k <= int'(T_BLUE0)) begin
            b = 0.0;
        end else begin
            b = 1.38517731223101504 * $ln(t - 10.0) - 3.05044858510917239;
        end
        res.red   = quantize_gain(r);
        res.green = quantize_gain(g);
        res.blue  = quantize_gain(b);
        return res;
    endfunction

    function automatic bit within_lsb(input logic [15:0] a, input logic [15:0] e);
        int d;
        d = int'(a) - int'(e);
        return d >= -1 && d <= 1;
    endfunction

    assign pending = gains_q.size();

    always @(posedge aclk) begin
        gains_t exp_g;
        if (!aresetn) begin
            errors <= 0;
            gains_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                gains_q.push_back(blackbody_gains(s_temperature_kelvin));
            end
            if (m_valid && m_ready) begin
                if (gains_q.size() == 0) begin
                    $display("%0t: unexpected transaction red=%0d green=%0d blue=%0d",
                             $time, m_red_gain, m_green_gain, m_blue_gain);
                    errors <= errors + 1;
                end else begin
                    exp_g = gains_q.pop_front();
                    if (!within_lsb(m_red_gain, exp_g.red) ||
                        !within_lsb(m_green_gain, exp_g.green) ||
                        !within_lsb(m_blue_gain, exp_g.blue)) begin
                        $display(
                            "%0t: mismatch expected r=%0d g=%0d b=%0d actual r=%0d g=%0d b=%0d",
                            $time, exp_g.red, exp_g.green, exp_g.blue,
                            m_red_gain, m_green_gain, m_blue_gain);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

/* verif/tb_color_temperature_to_rgb_gains_core.sv */
`timescale 1ns / 1ps
module tb_color_temperature_to_rgb_gains_core;
    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [14:0] s_temperature_kelvin;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_red_gain;
    logic [15:0] m_green_gain;
    logic [15:0] m_blue_gain;
    logic        s_fire_q;
    logic        m_fire_q;
    int          pending;
    int          errors;
    int          results_seen;
    bit          sender_done;

    color_temperature_to_rgb_gains_core #(.FRAC_BITS(15)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_temperature_kelvin(s_temperature_kelvin),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red_gain(m_red_gain), .m_green_gain(m_green_gain), .m_blue_gain(m_blue_gain)
    );

    color_temperature_to_rgb_gains_checker #(.FRAC_BITS(15)) checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_temperature_kelvin(s_temperature_kelvin),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red_gain(m_red_gain), .m_green_gain(m_green_gain), .m_blue_gain(m_blue_gain),
        .pending(pending), .errors(errors)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        s_fire_q <= aresetn && s_valid && s_ready;
        m_fire_q <= aresetn && m_valid && m_ready;
    end

    task automatic send_temperature(input logic [14:0] kelvin, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_temperature_kelvin <= kelvin;
        do @(negedge aclk); while (!s_fire_q);
    endtask

    function automatic logic [14:0] random_temperature();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return 15'($urandom_range(1000, 20000));
        if (sel < 8) return 15'($urandom_range(6400, 6800));
        if (sel < 9) return 15'($urandom_range(1800, 2100));
        return 15'($urandom);
    endfunction

    initial begin
        logic [14:0] directed[$];
        directed = '{15'd0, 15'd999, 15'd1000, 15'd1001, 15'd1899, 15'd1900, 15'd1901,
                     15'd2000, 15'd3000, 15'd6000, 15'd6001, 15'd6599, 15'd6600, 15'd6601,
                     15'd6700, 15'd10000, 15'd19999, 15'd20000, 15'd20001, 15'h5555,
                     15'h2AAA, 15'h7FFF, 15'h4000};
        sender_done = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_temperature_kelvin = '0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        foreach (directed[i]) send_temperature(directed[i], $urandom_range(0, 2));
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        for (int n = 0; n < 800; n++) begin
            if (n == 300) begin
                s_valid <= 1'b0;
                while (pending != 0) @(negedge aclk);
            end
            if ((n / 100) % 2 == 1) send_temperature(random_temperature(), 0);
            else send_temperature(random_temperature(), $urandom_range(0, 17));
        end
        s_valid <= 1'b0;
        sender_done = 1'b1;
    end

    initial begin
        m_ready = 1'b0;
        results_seen = 0;
        @(posedge aresetn);
        forever begin
            int gap;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (results_seen == 400) begin
                gap = 200;
            end else if ((results_seen / 100) % 2 == 1) begin
                gap = 0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(negedge aclk); while (!m_fire_q);
            results_seen++;
        end
    end

    initial begin
        @(posedge aresetn);
        wait (sender_done);
        while (pending != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
        if (errors == 0) begin
            $display("PASS color_temperature_to_rgb_gains_core");
        end else begin
            $display("FAIL color_temperature_to_rgb_gains_core");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL color_temperature_to_rgb_gains_core");
        $finish;
    end
endmodule

/* files.f */
+incdir+design
design/ctrgb_pkg.sv
design/ctrgb_log.sv
design/ctrgb_exp.sv
design/color_temperature_to_rgb_gains_core.sv
verif/color_temperature_to_rgb_gains_checker.sv
verif/tb_color_temperature_to_rgb_gains_core.sv
